@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the framer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while in reset.
`define FRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frm assertion failed");

// Next-cycle implication, gated off while in reset.
`define FRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frm assertion failed");

// Same-cycle implication that also holds around reset.
`define FRM_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("frm assertion failed");

`endif

@@ rtl/frm_pkg.sv @@
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants for the delimiter message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MAX_DELIM_DEF    = 8;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'd1;

    localparam logic [CFG_W-1:0] DELIM_BYTES_RST  = 64'h0000_0000_0000_0A0D;
    localparam logic [LEN_W-1:0] DELIM_LENGTH_RST = 4'd2;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_EMPTY,
        JOB_OVF
    } job_kind_t;

    // one completed message, handed from the front to the back
    typedef struct packed {
        job_kind_t kind;
        logic      bank;
    } job_t;

    // back tells the front that a buffer bank has been fully read out
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

`default_nettype wire

@@ rtl/delimiter_message_framer.sv @@
// ----------------------------------------------------------------------------
// delimiter_message_framer
// Splits a received byte stream into messages ended by a configurable
// delimiter of 1 to MAX_DELIMITER bytes and replays each message's bytes.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  input     | in_valid / in_ready    | rx_byte
//  output    | out_valid / out_ready  | message_byte, last_byte,
//            |                        | empty_message, overflowed
//  config    | cfg_write (no wait)    | cfg_index, cfg_data
//
//  Input: one byte per cycle while in_ready is high; each byte's store
//  write and delimiter compare in the front finish in the accept cycle.
//  Output: a completed message is popped from the job queue, then its
//  bytes are replayed with one store read a cycle while out_ready does
//  not stall the output register; an empty or overflow message gives
//  its single item.
//  in_ready drops while the two-entry job queue is full or while the
//  store bank the front would fill is still being replayed.
//  Reset clears all control state; the store needs no clearing pass.
//
`default_nettype none

module delimiter_message_framer #(
    parameter int BUFFER_DEPTH  = frm_pkg::BUFFER_DEPTH_DEF,
    parameter int MAX_DELIMITER = frm_pkg::MAX_DELIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [frm_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [frm_pkg::BYTE_W-1:0]    message_byte,
    output logic                          last_byte,
    output logic                          empty_message,
    output logic                          overflowed
);
    import frm_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    // front -> queue
    logic             push, q_full;
    job_t             push_job;
    logic [CNT_W-1:0] push_len;

    // queue -> back
    logic             pop, q_valid;
    job_t             head_job;
    logic [CNT_W-1:0] head_len;

    // store write path and bank release
    logic              wr_en;
    logic [ADDR_W:0]   wr_addr;
    logic [BYTE_W-1:0] wr_data;
    rel_t              rel;

    // Front: takes bytes, writes the store bank it owns, tracks the
    // delimiter match and queues one job per completed message.
    frm_front #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .MAX_DELIMITER (MAX_DELIMITER),
        .CNT_W         (CNT_W),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (push),
        .q_job     (push_job),
        .q_len     (push_len),
        .rel       (rel),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    frm_queue #(
        .CNT_W (CNT_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .push_len (push_len),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head_job (head_job),
        .head_len (head_len)
    );

    // Back: owns the store, replays a job through the output register and
    // hands the bank back to the front after its last byte.
    frm_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CNT_W        (CNT_W),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .q_valid       (q_valid),
        .q_job         (head_job),
        .q_len         (head_len),
        .q_pop         (pop),
        .rel           (rel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .message_byte  (message_byte),
        .last_byte     (last_byte),
        .empty_message (empty_message),
        .overflowed    (overflowed)
    );

endmodule

`default_nettype wire

@@ rtl/frm_front.sv @@
// ----------------------------------------------------------------------------
// frm_front
// Accepts received bytes, stores them and matches the delimiter; queues a
// job for each completed message.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_front #(
    parameter int BUFFER_DEPTH  = frm_pkg::BUFFER_DEPTH_DEF,
    parameter int MAX_DELIMITER = frm_pkg::MAX_DELIM_DEF,
    parameter int CNT_W         = $clog2(BUFFER_DEPTH + 1),
    parameter int ADDR_W        = $clog2(BUFFER_DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [frm_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                            q_full,
    output logic                            q_push,
    output frm_pkg::job_t                   q_job,
    output logic [CNT_W-1:0]                q_len,
    input  frm_pkg::rel_t                   rel,
    output logic                            wr_en,
    output logic [ADDR_W:0]                 wr_addr,
    output logic [frm_pkg::BYTE_W-1:0]      wr_data
);
    import frm_pkg::*;

    localparam int DLM_W = BYTE_W * MAX_DELIMITER;

    logic [DLM_W-1:0] dlm_bytes_reg;
    logic [LEN_W-1:0] dlm_len_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] match_reg, match_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;

    logic [LEN_W-1:0]  len, pos, pos_inc;
    logic [BYTE_W-1:0] want;
    logic              accept, hit, done, room;
    logic [CNT_W-1:0]  count_inc, len_ext, msg_len;

    always_comb
    begin
        if (dlm_len_reg == '0)
            len = LEN_W'(1);
        else if (dlm_len_reg > LEN_W'(MAX_DELIMITER))
            len = LEN_W'(MAX_DELIMITER);
        else
            len = dlm_len_reg;
    end

    assign pos     = (match_reg >= len) ? '0 : match_reg;
    assign want    = BYTE_W'(dlm_bytes_reg >> {pos, 3'b000});
    assign hit     = (rx_byte == want);
    assign pos_inc = pos + LEN_W'(1);
    assign done    = hit && (pos_inc == len);

    assign room      = (count_reg < CNT_W'(BUFFER_DEPTH));
    assign count_inc = room ? count_reg + CNT_W'(1) : count_reg;
    assign len_ext   = CNT_W'(len);
    assign msg_len   = (count_inc >= len_ext) ? count_inc - len_ext : '0;

    assign in_ready = !q_full && !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;

    // store write: the dropped byte of a full buffer is not written
    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, count_reg[ADDR_W-1:0]};
    assign wr_data = rx_byte;

    always_comb
    begin
        q_job.bank = bank_reg;
        if (ovf_reg || !room)
            q_job.kind = JOB_OVF;
        else if (msg_len == '0)
            q_job.kind = JOB_EMPTY;
        else
            q_job.kind = JOB_DATA;
    end
    assign q_len  = msg_len;
    assign q_push = accept && done;

    always_comb
    begin
        count_next = count_reg;
        match_next = match_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
            busy_next[rel.bank] = 1'b0;
        if (accept)
        begin
            count_next = count_inc;
            ovf_next   = ovf_reg || !room;
            match_next = hit ? pos_inc : '0;
            if (done)
            begin
                count_next = '0;
                match_next = '0;
                ovf_next   = 1'b0;
                if (q_job.kind == JOB_DATA)
                begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = !bank_reg;
                end
            end
        end
        if (cfg_write)
            match_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlm_bytes_reg <= DELIM_BYTES_RST[DLM_W-1:0];
            dlm_len_reg   <= DELIM_LENGTH_RST;
            count_reg     <= '0;
            match_reg     <= '0;
            ovf_reg       <= 1'b0;
            bank_reg      <= 1'b0;
            busy_reg      <= '0;
        end
        else
        begin
            count_reg <= count_next;
            match_reg <= match_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DELIM_BYTES:  dlm_bytes_reg <= cfg_data[DLM_W-1:0];
                    REG_DELIM_LENGTH: dlm_len_reg   <= cfg_data[LEN_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/frm_queue.sv @@
// ----------------------------------------------------------------------------
// frm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_queue #(
    parameter int CNT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  frm_pkg::job_t    push_job,
    input  logic [CNT_W-1:0] push_len,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output frm_pkg::job_t    head_job,
    output logic [CNT_W-1:0] head_len
);
    import frm_pkg::*;

    job_t             job_q [2];
    logic [CNT_W-1:0] len_q [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       fill_reg;
    logic             do_push, do_pop;

    assign full     = (fill_reg == 2'd2);
    assign valid    = (fill_reg != 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign head_job = job_q[rptr_reg];
    assign head_len = len_q[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            job_q[wptr_reg] <= push_job;
            len_q[wptr_reg] <= push_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/frm_back.sv @@
// ----------------------------------------------------------------------------
// frm_back
// Holds the two-bank message store and replays completed messages one
// result item at a time into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_back #(
    parameter int BUFFER_DEPTH = frm_pkg::BUFFER_DEPTH_DEF,
    parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1),
    parameter int ADDR_W       = $clog2(BUFFER_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [ADDR_W:0]            wr_addr,
    input  logic [frm_pkg::BYTE_W-1:0] wr_data,
    input  logic                       q_valid,
    input  frm_pkg::job_t              q_job,
    input  logic [CNT_W-1:0]           q_len,
    output logic                       q_pop,
    output frm_pkg::rel_t              rel,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [frm_pkg::BYTE_W-1:0] message_byte,
    output logic                       last_byte,
    output logic                       empty_message,
    output logic                       overflowed
);
    import frm_pkg::*;

    localparam int MEM_DEPTH = 2 << ADDR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_DATA
    } state_t;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    state_t            state_reg;
    job_t              job_reg;
    logic [CNT_W-1:0]  len_reg, idx_reg;
    logic              out_valid_reg, last_reg, empty_reg, ovf_reg;
    logic [BYTE_W-1:0] byte_reg;

    logic              out_free, rd_en, tail, load;
    logic [ADDR_W:0]   rd_addr;

    assign out_free = !out_valid_reg || out_ready;
    assign tail     = (idx_reg == len_reg);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    // a new item enters the output register this cycle
    assign load     = (state_reg inside {ST_SINGLE, ST_DATA}) && out_free;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {job_reg.bank, idx_reg[ADDR_W-1:0]};
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_job.kind == JOB_DATA)
                begin
                    rd_en   = 1'b1;
                    rd_addr = {q_job.bank, {ADDR_W{1'b0}}};
                end
            end
            ST_DATA:
                rd_en = out_free && !tail;
            default: ;
        endcase
    end

    // bank is free once its last byte has moved into the output register
    assign rel.valid = (state_reg == ST_DATA) && out_free && tail;
    assign rel.bank  = job_reg.bank;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            job_reg       <= '{kind: JOB_DATA, bank: 1'b0};
            len_reg       <= '0;
            idx_reg       <= '0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (out_ready && !load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg <= q_job;
                        len_reg <= q_len;
                        idx_reg <= CNT_W'(1);
                        state_reg <= (q_job.kind == JOB_DATA) ? ST_DATA : ST_SINGLE;
                    end
                end
                ST_SINGLE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= '0;
                        last_reg      <= 1'b1;
                        empty_reg     <= (job_reg.kind == JOB_EMPTY);
                        ovf_reg       <= (job_reg.kind == JOB_OVF);
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_DATA:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        byte_reg      <= rdata_reg;
                        last_reg      <= tail;
                        empty_reg     <= 1'b0;
                        ovf_reg       <= 1'b0;
                        if (tail)
                            state_reg <= ST_IDLE;
                        else
                            idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign message_byte  = byte_reg;
    assign last_byte     = last_reg;
    assign empty_message = empty_reg;
    assign overflowed    = ovf_reg;

endmodule

`default_nettype wire

@@ rtl/frm_checker.sv @@
// ----------------------------------------------------------------------------
// frm_checker
// Port-level checks on the framer's result items, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module frm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] message_byte,
    input logic       last_byte,
    input logic       empty_message,
    input logic       overflowed
);

    // stalled item holds
    `FRM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(message_byte) && $stable(last_byte))

    // empty item is a lone zero item
    `FRM_ASSERT_IMP(a_empty_form, clk, rst_n, out_valid && empty_message, last_byte && !overflowed && message_byte == 8'd0)

    // overflow item is a lone zero item
    `FRM_ASSERT_IMP(a_ovf_form, clk, rst_n, out_valid && overflowed, last_byte && !empty_message && message_byte == 8'd0)

    // nothing offered right out of reset
    `FRM_ASSERT_ALW(a_reset_quiet, clk, $rose(rst_n), !out_valid)

endmodule

bind delimiter_message_framer frm_checker u_frm_checker (.*);

`default_nettype wire
